>>> rtl/nwc_pkg.sv
// Shared types and constants for the NewReno congestion window block.
package nwc_pkg;

    // Field widths
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned SEGS_W  = 16;
    localparam int unsigned BYTES_W = 32;
    localparam int unsigned MSS_W   = 16;

    // Stream payload widths (packed, padded to whole bytes)
    localparam int unsigned S_TDATA_W = 80;
    localparam int unsigned M_TDATA_W = 72;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_ACK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOSS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD = 2'd2;

    // Reset values
    localparam logic [MSS_W-1:0]   MSS_RST    = 16'd1448;
    localparam logic [BYTES_W-1:0] WINDOW_RST = 32'd1448;
    localparam logic [BYTES_W-1:0] THRESH_RST = 32'hFFFF_FFFF;

    // One input item
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [SEGS_W-1:0]  acked_segments;
        logic [BYTES_W-1:0] in_flight;
        logic [BYTES_W-1:0] window_value;
    } t_req;

    // One result item
    typedef struct packed {
        logic               slow_start;
        logic [BYTES_W-1:0] threshold;
        logic [BYTES_W-1:0] window;
    } t_rsp;

    // Saturating 32-bit add of two 32-bit values
    function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                    input logic [BYTES_W-1:0] b);
        logic [BYTES_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        sat_add = sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
    endfunction

endpackage

>>> rtl/nwc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module nwc_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nwc_pkg::BYTES_W-1:0] i_dividend,
    input  logic [nwc_pkg::BYTES_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [nwc_pkg::BYTES_W-1:0] o_quotient
);
    import nwc_pkg::*;

    localparam int unsigned CNT_W = $clog2(BYTES_W);

    logic               r_busy,  n_busy;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [BYTES_W-1:0] r_rem,   n_rem;
    logic [BYTES_W-1:0] r_quo,   n_quo;
    logic [BYTES_W-1:0] r_div,   n_div;
    logic               r_done,  n_done;

    logic [BYTES_W:0]   shifted;
    logic [BYTES_W+1:0] diff;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_quo[BYTES_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
    end

    // Step sequencing
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (!diff[BYTES_W+1]) begin
                n_rem = diff[BYTES_W-1:0];
                n_quo = {r_quo[BYTES_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[BYTES_W-1:0];
                n_quo = {r_quo[BYTES_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(BYTES_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/nwc_core.sv
// Window and threshold state with the per-item sequencer.
module nwc_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  nwc_pkg::t_req             i_req,
    input  logic [nwc_pkg::MSS_W-1:0] i_mss,
    input  logic                      i_out_free,
    output logic                      o_idle,
    output logic                      o_done,
    output nwc_pkg::t_rsp             o_rsp
);
    import nwc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SS   = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]         r_state,    n_state;
    logic [BYTES_W-1:0] r_cwnd,     n_cwnd;
    logic [BYTES_W-1:0] r_ssthresh, n_ssthresh;
    logic [SEGS_W-1:0]  r_segs,     n_segs;
    logic [BYTES_W-1:0] r_sq,       n_sq;
    logic [BYTES_W-1:0] r_inc,      n_inc;

    logic               below;
    logic [BYTES_W-1:0] add_b;
    logic [BYTES_W-1:0] add_sum;
    logic [BYTES_W-1:0] mss_ext;
    logic [BYTES_W-1:0] twice_mss;
    logic [BYTES_W-1:0] half_flight;
    logic               div_start;
    logic               div_done;
    logic [BYTES_W-1:0] div_quo;

    assign mss_ext     = {{(BYTES_W-MSS_W){1'b0}}, i_mss};
    assign twice_mss   = {{(BYTES_W-MSS_W-1){1'b0}}, i_mss, 1'b0};
    assign half_flight = {1'b0, i_req.in_flight[BYTES_W-1:1]};
    assign below       = r_cwnd < r_ssthresh;

    // Shared saturating adder: segment size in slow start, increment otherwise
    assign add_b   = (r_state == ST_SS) ? mss_ext : r_inc;
    assign add_sum = sat_add(r_cwnd, add_b);

    assign div_start = (r_state == ST_CHK) && !below && (r_segs != '0) && (r_cwnd != '0);

    nwc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sq),
        .i_divisor  (r_cwnd),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_cwnd     = r_cwnd;
        n_ssthresh = r_ssthresh;
        n_segs     = r_segs;
        n_sq       = r_sq;
        n_inc      = r_inc;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DONE;
                    case (i_req.func)
                        FUNC_ACK: begin
                            n_segs  = i_req.acked_segments;
                            n_state = ST_SS;
                        end
                        FUNC_LOSS: begin
                            n_ssthresh = (twice_mss > half_flight) ? twice_mss : half_flight;
                        end
                        FUNC_LOAD: begin
                            n_cwnd = i_req.window_value;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SS: begin
                // mss squared fits 32 bits
                n_sq = mss_ext * mss_ext;
                if (below && (r_segs != '0)) begin
                    n_cwnd = add_sum;
                    n_segs = r_segs - SEGS_W'(1);
                end
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (!below && (r_segs != '0)) begin
                    if (r_cwnd == '0) begin
                        n_inc   = (i_mss == '0) ? BYTES_W'(1) : mss_ext;
                        n_state = ST_ADD;
                    end else begin
                        n_state = ST_DIV;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_inc   = (div_quo == '0) ? BYTES_W'(1) : div_quo;
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_cwnd  = add_sum;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cwnd     <= WINDOW_RST;
            r_ssthresh <= THRESH_RST;
        end else begin
            r_state    <= n_state;
            r_cwnd     <= n_cwnd;
            r_ssthresh <= n_ssthresh;
        end
        r_segs <= n_segs;
        r_sq   <= n_sq;
        r_inc  <= n_inc;
    end

    assign o_idle           = (r_state == ST_IDLE);
    assign o_done           = (r_state == ST_DONE) && i_out_free;
    assign o_rsp.window     = r_cwnd;
    assign o_rsp.threshold  = r_ssthresh;
    assign o_rsp.slow_start = below;

`ifndef SYNTHESIS
    a_div_start_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == ST_CHK))
        else $error("divider started outside check step");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished while sequencer not waiting");
    a_add_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |=> (r_cwnd >= $past(r_cwnd)))
        else $error("window wrapped on increase");
    a_loss_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_idle && i_start && (i_req.func == FUNC_LOSS)) |=> (r_ssthresh >= $past(twice_mss)))
        else $error("threshold below two segments after loss");
`endif

endmodule

>>> rtl/newreno_window_control.sv
// Top level of the NewReno congestion window control block.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+--------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: func; tdata: item fields
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: window, threshold, flag
//  cfg      | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Loss, load and unused codes go from idle straight to the done state; an ack
// passes the slow-start and check steps, and in congestion avoidance also the
// 32-step radix-2 divider that forms mss*mss/window (skipped with a zero window)
// and the add step. One item is worked at a time.
// A finished result sits in the output register, so the next item is taken
// while it waits. Reset (synchronous, active low) restores the registers and
// loads window and threshold from the initial register reset values.
module newreno_window_control (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // [1:0] func
    input  logic [nwc_pkg::FUNC_W-1:0]      s_axis_tuser,
    // [15:0] acked_segments, [47:16] in_flight, [79:48] window_value
    input  logic [nwc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] window, [63:32] threshold, [64] slow_start, [71:65] zero
    output logic [nwc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [nwc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nwc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import nwc_pkg::*;

    logic [MSS_W-1:0] r_mss;
    logic             r_out_valid;
    t_rsp             r_out;
    t_req             req;
    t_rsp             rsp;
    logic             core_idle;
    logic             core_done;
    logic             out_free;
    logic             in_xfer;

    // Unpack the input transfer
    assign req.func           = s_axis_tuser;
    assign req.acked_segments = s_axis_tdata[15:0];
    assign req.in_flight      = s_axis_tdata[47:16];
    assign req.window_value   = s_axis_tdata[79:48];

    assign s_axis_tready = core_idle;
    assign in_xfer       = s_axis_tvalid && core_idle;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Configuration writes; the initial window and threshold only matter
    // at reset, where they hold their reset values, so they are not kept
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss <= MSS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEGMENT_SIZE:      r_mss <= i_cfg_data[MSS_W-1:0];
                CFG_INITIAL_WINDOW:    ;
                CFG_INITIAL_THRESHOLD: ;
                default:               ;
            endcase
        end
    end

    nwc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer),
        .i_req      (req),
        .i_mss      (r_mss),
        .i_out_free (out_free),
        .o_idle     (core_idle),
        .o_done     (core_done),
        .o_rsp      (rsp)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (core_done) begin
            r_out <= rsp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-2*BYTES_W-1){1'b0}},
                            r_out.slow_start, r_out.threshold, r_out.window};

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the NewReno congestion window block (directed and random items).
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nwc_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [FUNC_W-1:0]    FUNC_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE  = 2'd3;

    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int TAIL_CYCLES = 50;    // above the slowest item's latency
    localparam int PHASE_ITEMS = 230;
    localparam int NUM_PHASES  = 6;

    // DUT inputs start from known values
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic [FUNC_W-1:0]     s_axis_tuser  = '0;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    newreno_window_control dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Register copies and flow state as the block should hold them
    logic [MSS_W-1:0]   mss_reg      = MSS_RST;
    logic [BYTES_W-1:0] init_win_reg = WINDOW_RST;
    logic [BYTES_W-1:0] init_thr_reg = THRESH_RST;
    logic [BYTES_W-1:0] cwnd         = WINDOW_RST;
    logic [BYTES_W-1:0] ssthresh     = THRESH_RST;

    t_req pending_items[$];     // items waiting to be offered
    t_rsp expected_rsp[$];      // window updates still to come out
    t_req offered;              // item on the input bus
    bit   item_taken = 1'b0;
    bit   idle_on    = 1'b1;
    bit   hold_req   = 1'b0;
    bit   failed     = 1'b0;
    int   send_gap   = 0;
    int   stall_cnt  = 0;
    int   hold_cnt   = 0;

    // Add that sticks at all-ones
    function automatic logic [BYTES_W-1:0] add_sat(input logic [BYTES_W-1:0] a,
                                                   input logic [63:0] b);
        logic [64:0] sum;
        sum = {33'd0, a} + {1'b0, b};
        return (sum > 65'hFFFF_FFFF) ? '1 : sum[BYTES_W-1:0];
    endfunction

    // Apply one item to the flow state and return the window report
    function automatic t_rsp advance_window(input t_req it);
        logic [SEGS_W-1:0]  segs;
        logic [63:0]        inc;
        logic [BYTES_W-1:0] twice;
        logic [BYTES_W-1:0] half;
        t_rsp               r;
        segs = it.acked_segments;
        case (it.func)
            FUNC_ACK: begin
                // slow start uses up one acked segment
                if (cwnd < ssthresh && segs != '0) begin
                    cwnd = add_sat(cwnd, 64'(mss_reg));
                    segs = segs - SEGS_W'(1);
                end
                // congestion avoidance on what is left
                if (cwnd >= ssthresh && segs != '0) begin
                    if (cwnd == '0)
                        inc = 64'(mss_reg);
                    else
                        inc = (64'(mss_reg) * 64'(mss_reg)) / 64'(cwnd);
                    if (inc == 64'd0)
                        inc = 64'd1;
                    cwnd = add_sat(cwnd, inc);
                end
            end
            FUNC_LOSS: begin
                twice = 32'({mss_reg, 1'b0});
                half  = it.in_flight >> 1;
                ssthresh = (twice > half) ? twice : half;
            end
            FUNC_LOAD: cwnd = it.window_value;
            default: ;
        endcase
        r.window     = cwnd;
        r.threshold  = ssthresh;
        r.slow_start = (cwnd < ssthresh);
        return r;
    endfunction

    function automatic t_req make_item(input logic [FUNC_W-1:0] f, input logic [SEGS_W-1:0] s,
                                       input logic [BYTES_W-1:0] fl,
                                       input logic [BYTES_W-1:0] wv);
        t_req it;
        it.func           = f;
        it.acked_segments = s;
        it.in_flight      = fl;
        it.window_value   = wv;
        return it;
    endfunction

    // Random item, weighted toward acks and values near the interesting edges
    function automatic t_req rand_item();
        t_req it;
        int   pick;
        it.acked_segments = SEGS_W'($urandom());
        it.in_flight      = $urandom();
        it.window_value   = $urandom();
        pick = $urandom_range(0, 19);
        if (pick <= 10)      it.func = FUNC_ACK;
        else if (pick <= 13) it.func = FUNC_LOSS;
        else if (pick <= 18) it.func = FUNC_LOAD;
        else                 it.func = FUNC_NONE;
        case ($urandom_range(0, 9))
            0:       it.acked_segments = '0;
            1, 2, 3: it.acked_segments = 16'd1;
            4, 5:    it.acked_segments = SEGS_W'($urandom_range(2, 6));
            9:       it.acked_segments = '1;
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0:       it.in_flight = $urandom_range(0, 4 * mss_reg + 1);
            1:       it.in_flight = '1;
            2:       it.in_flight = $urandom_range(0, 65535);
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0:       it.window_value = '0;
            1:       it.window_value = '1;
            2:       it.window_value = 32'hFFFF_FFFF - $urandom_range(0, 70000);
            3:       it.window_value = ssthresh + $urandom_range(0, 8) - 32'd4;
            4:       it.window_value = $urandom_range(1, 200000);
            default: ;
        endcase
        return it;
    endfunction

    // One register write; predictor copy updated at the transfer edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SEGMENT_SIZE:      mss_reg      = val[MSS_W-1:0];
            CFG_INITIAL_WINDOW:    init_win_reg = val;
            CFG_INITIAL_THRESHOLD: init_thr_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sender stays quiet until every result is back
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    // Input driver: holds an item until its transfer, with random gaps
    always @(negedge i_clk) begin : drive_items
        if (s_axis_tvalid && !item_taken) begin
            // still waiting for the transfer
        end else if (!i_rst_n || pending_items.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 7) - 1;
            s_axis_tvalid <= 1'b0;
        end else begin
            offered = pending_items.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= offered.func;
            s_axis_tdata  <= {offered.window_value, offered.in_flight, offered.acked_segments};
        end
        item_taken = 1'b0;
    end

    // Output ready: random stall bursts and one long hold-off on request
    always @(negedge i_clk) begin : drive_ready
        logic rdy;
        rdy = 1'b1;
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            rdy = 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES - 1;
            rdy = 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt = stall_cnt - 1;
            rdy = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_cnt = $urandom_range(1, 7) - 1;
            rdy = 1'b0;
        end
        m_axis_tready <= rdy;
    end

    // Monitor: predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin : score
        t_rsp got;
        t_rsp want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            item_taken = 1'b1;
            expected_rsp.push_back(advance_window(offered));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_rsp)-1:0];
            if (expected_rsp.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_axis_tdata);
                failed = 1'b1;
            end else begin
                want = expected_rsp.pop_front();
                if (got.window !== want.window) begin
                    $error("window: expected %h, got %h", want.window, got.window);
                    failed = 1'b1;
                end
                if (got.threshold !== want.threshold) begin
                    $error("threshold: expected %h, got %h", want.threshold, got.threshold);
                    failed = 1'b1;
                end
                if (got.slow_start !== want.slow_start) begin
                    $error("slow_start: expected %b, got %b", want.slow_start, got.slow_start);
                    failed = 1'b1;
                end
                if (m_axis_tdata[M_TDATA_W-1:$bits(t_rsp)] !== '0) begin
                    $error("pad: expected %h, got %h", 7'd0,
                           m_axis_tdata[M_TDATA_W-1:$bits(t_rsp)]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Stimulus sequence
    initial begin : run
        logic [MSS_W-1:0] mss_set[NUM_PHASES];
        mss_set = '{16'd536, 16'd1, 16'd65535, 16'd0, 16'd1448, 16'd1448};
        mss_set[4] = MSS_W'($urandom_range(2, 65534));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: slow start, saturation, loss extremes, unused code
        pending_items.push_back(make_item(FUNC_ACK, 16'd0, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_ACK, 16'd1, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_NONE, SEGS_W'($urandom()), $urandom(),
                                          $urandom()));
        pending_items.push_back(make_item(FUNC_LOAD, SEGS_W'($urandom()), $urandom(),
                                          32'hFFFF_FF00));
        pending_items.push_back(make_item(FUNC_ACK, 16'd2, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_ACK, 16'hFFFF, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_LOSS, SEGS_W'($urandom()), 32'd0, $urandom()));
        pending_items.push_back(make_item(FUNC_LOSS, SEGS_W'($urandom()), 32'hFFFF_FFFF,
                                          $urandom()));
        pending_items.push_back(make_item(FUNC_LOAD, SEGS_W'($urandom()), $urandom(),
                                          32'h7FFF_FFFF));
        pending_items.push_back(make_item(FUNC_ACK, 16'd1, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_LOSS, SEGS_W'($urandom()), 32'd100, $urandom()));
        pending_items.push_back(make_item(FUNC_LOAD, SEGS_W'($urandom()), $urandom(), 32'd1000));
        pending_items.push_back(make_item(FUNC_ACK, 16'hFFFF, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_ACK, 16'd2, $urandom(), $urandom()));
        wait_drained();

        // Zero segment size (upper data bits ignored), out-of-range register index
        write_reg(CFG_SEGMENT_SIZE, 32'hABCD_0000);
        write_reg(CFG_NONE, $urandom());
        pending_items.push_back(make_item(FUNC_ACK, 16'd4, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_LOSS, SEGS_W'($urandom()), 32'd1, $urandom()));
        pending_items.push_back(make_item(FUNC_LOAD, SEGS_W'($urandom()), $urandom(), 32'd0));
        pending_items.push_back(make_item(FUNC_ACK, 16'd1, $urandom(), $urandom()));
        wait_drained();

        // Largest segment size: zero window in congestion avoidance, huge increments
        write_reg(CFG_SEGMENT_SIZE, 32'h0000_FFFF);
        write_reg(CFG_INITIAL_WINDOW, 32'hFFFF_FFFF);
        write_reg(CFG_INITIAL_THRESHOLD, 32'd0);
        pending_items.push_back(make_item(FUNC_LOAD, SEGS_W'($urandom()), $urandom(), 32'd0));
        pending_items.push_back(make_item(FUNC_ACK, 16'd1, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_LOAD, SEGS_W'($urandom()), $urandom(), 32'd1));
        pending_items.push_back(make_item(FUNC_ACK, 16'd1, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_LOSS, SEGS_W'($urandom()), 32'd0, $urandom()));
        pending_items.push_back(make_item(FUNC_LOAD, SEGS_W'($urandom()), $urandom(),
                                          32'hFFFF_FFFF));
        pending_items.push_back(make_item(FUNC_ACK, 16'd1, $urandom(), $urandom()));
        wait_drained();

        // Smallest segment size: increment rounds down to zero, forced to one
        write_reg(CFG_SEGMENT_SIZE, 32'h0000_0001);
        write_reg(CFG_INITIAL_WINDOW, 32'd1);
        write_reg(CFG_INITIAL_THRESHOLD, 32'hFFFF_FFFF);
        pending_items.push_back(make_item(FUNC_ACK, 16'd1, $urandom(), $urandom()));
        pending_items.push_back(make_item(FUNC_LOSS, SEGS_W'($urandom()), 32'd0, $urandom()));
        pending_items.push_back(make_item(FUNC_LOAD, SEGS_W'($urandom()), $urandom(), 32'd1));
        pending_items.push_back(make_item(FUNC_ACK, 16'd5, $urandom(), $urandom()));

        // Random phases, one setting each; the last one runs without idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_reg(CFG_SEGMENT_SIZE, {16'($urandom()), mss_set[p]});
            write_reg(CFG_INITIAL_WINDOW, (p == 2) ? 32'd1 : $urandom_range(1, 32'hFFFF_FFFF));
            write_reg(CFG_INITIAL_THRESHOLD, $urandom());
            if (p == 3)
                write_reg(CFG_NONE, $urandom());
            idle_on = (p != NUM_PHASES - 1);
            // receiver holds off while the sender keeps offering
            if (p == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_items.push_back(rand_item());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (!failed && expected_rsp.size() == 0)
            $display("** newreno_window_control: PASSED **");
        else
            $display("** newreno_window_control: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("** newreno_window_control: FAILED **");
        $finish;
    end

endmodule

>>> newreno_window_control.f
rtl/nwc_pkg.sv
rtl/nwc_divider.sv
rtl/nwc_core.sv
rtl/newreno_window_control.sv
tb/testbench.sv
